@@ rtl/fbba_pkg.sv @@
// Shared types, constants and helpers for the free-block bitmap allocator.
// No dependencies; compiled first.
package fbba_pkg;

  localparam int MAP_WORDS = 256;
  localparam int WORD_BITS = 32;
  localparam int AW        = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int BLK_W     = 13;
  localparam int WIN_W     = 9;
  localparam int GRP_W     = 16;
  localparam int GRP_N     = MAP_WORDS / GRP_W;
  localparam int GIDX_W    = $clog2(GRP_W);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 9;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [AW-1:0]        waddr_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_CHECK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOT_OPEN = 2'd1,
    STAT_NO_FREE  = 2'd2,
    STAT_RANGE    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORDS_IN_USE = 1'd0,
    REG_FS_OPEN      = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_MOD
  } state_e;

  // summary update: word at addr is now nonzero or not
  typedef struct packed {
    logic   en;
    waddr_t addr;
    logic   nz;
  } sum_upd_t;

  function automatic logic [GIDX_W-1:0] lowest16(input logic [GRP_W-1:0] v);
    logic [GIDX_W-1:0] idx;
    idx = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (v[i]) idx = GIDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [BIT_W-1:0] lowest32(input word_t v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ rtl/fbba_if.sv @@
// Request and response channel interfaces (valid/ready plus payload).
// Depends on nothing; compiled after fbba_pkg.
interface fbba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [12:0] block_index;

  modport source (output valid, operation, block_index, input ready);
  modport sink   (input valid, operation, block_index, output ready);
endinterface

interface fbba_rsp_if;
  logic        valid;
  logic        ready;
  logic [12:0] allocated_block;
  logic        is_allocated;
  logic [1:0]  status;

  modport source (output valid, allocated_block, is_allocated, status, input ready);
  modport sink   (input valid, allocated_block, is_allocated, status, output ready);
endinterface

@@ rtl/fbba_map_ram.sv @@
// Bitmap word store: synchronous RAM with a registered read.
// Per-word valid bits make unwritten words read as all free. Uses fbba_pkg.
module fbba_map_ram (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           re_i,
  input  fbba_pkg::waddr_t raddr_i,
  output fbba_pkg::word_t  rdata_o,
  input  logic           we_i,
  input  fbba_pkg::waddr_t waddr_i,
  input  fbba_pkg::word_t  wdata_i
);
  import fbba_pkg::*;

  word_t                mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  word_t                rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) vld_q[waddr_i] <= 1'b1;
      if (re_i) rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '1;

endmodule

@@ rtl/fbba_first_free.sv @@
// Summary register of nonzero bitmap words and first-fit word finder.
// Uses fbba_pkg.
module fbba_first_free (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [fbba_pkg::WIN_W-1:0] eff_words_i,
  input  fbba_pkg::sum_upd_t      upd_i,
  output logic                    found_o,
  output fbba_pkg::waddr_t        word_o
);
  import fbba_pkg::*;

  logic [MAP_WORDS-1:0] nz_q;
  logic [MAP_WORDS-1:0] cand;
  logic [GRP_N-1:0]     grp_any;
  logic [GIDX_W-1:0]    grp_idx [GRP_N];
  logic [GIDX_W-1:0]    grp_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q <= '1;
    end else if (upd_i.en) begin
      nz_q[upd_i.addr] <= upd_i.nz;
    end
  end

  always_comb begin
    for (int i = 0; i < MAP_WORDS; i++) begin
      cand[i] = nz_q[i] && (WIN_W'(i) < eff_words_i);
    end
    for (int g = 0; g < GRP_N; g++) begin
      grp_any[g] = |cand[g*GRP_W +: GRP_W];
      grp_idx[g] = lowest16(cand[g*GRP_W +: GRP_W]);
    end
  end

  assign grp_sel = lowest16(grp_any);
  assign found_o = |grp_any;
  assign word_o  = {grp_sel, grp_idx[grp_sel]};

  a_found_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> (WIN_W'(word_o) < eff_words_i))
    else $error("first free word beyond words in use");
  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> nz_q[word_o])
    else $error("first free word is marked empty");
  a_update_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.en |=> (nz_q[$past(upd_i.addr)] == $past(upd_i.nz)))
    else $error("summary bit not updated");

endmodule

@@ rtl/free_block_bitmap_allocator_core.sv @@
// Top level of the free-block bitmap allocator: request sequencer, config regs,
// output register. Uses fbba_pkg, fbba_if, fbba_map_ram, fbba_first_free.
//
//   channel  dir  handshake    word
//   req_i    in   valid/ready  operation, block_index
//   rsp_o    out  valid/ready  allocated_block, is_allocated, status
//   cfg      in   cfg_we_i     cfg_idx_i, cfg_wdata_i (no wait)
//
// Each request passes through accept, word lookup and RAM read, then
// read-modify-write of the bitmap word and load of the response register.
// The three-state sequencer sets this order: the modify step needs the
// registered RAM read data of the lookup step.
// Reset marks every block free; no clearing pass is needed.
// A stalled response holds the modify step; a new request is taken while
// the previous response still waits.
module free_block_bitmap_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fbba_req_if.sink                      req_i,
  fbba_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [fbba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fbba_pkg::CFG_DW-1:0]   cfg_wdata_i
);
  import fbba_pkg::*;

  state_e           state_q, state_d;
  logic [WIN_W-1:0] words_q;
  logic             open_q;
  logic [WIN_W-1:0] eff_words;

  op_e              op_q;
  logic [BLK_W-1:0] blk_q;
  status_e          stat_q, stat_d;
  waddr_t           addr_q, addr_d;

  logic             found;
  waddr_t           found_word;
  sum_upd_t         upd;

  word_t            rdata, wdata;
  logic [BIT_W-1:0] low_bit;
  word_t            bit_mask;
  logic             map_re, map_we, out_load, ok;

  logic             out_valid_q;
  logic [BLK_W-1:0] out_blk_q;
  logic             out_used_q;
  status_e          out_stat_q;

  assign eff_words = (words_q > WIN_W'(MAP_WORDS)) ? WIN_W'(MAP_WORDS) : words_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= WIN_W'(256);
      open_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WORDS_IN_USE: words_q <= cfg_wdata_i[WIN_W-1:0];
        REG_FS_OPEN:      open_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign out_load = (state_q == S_MOD) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (req_i.valid) state_d = S_LOOK;
      S_LOOK:  state_d = S_MOD;
      S_MOD:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign map_re      = (state_q == S_LOOK);

  always_comb begin
    stat_d = STAT_OK;
    addr_d = blk_q[BLK_W-1 -: AW];
    if (!open_q) begin
      stat_d = STAT_NOT_OPEN;
    end else if (op_q == OP_ALLOC) begin
      addr_d = found_word;
      if (!found) stat_d = STAT_NO_FREE;
    end else if (WIN_W'(blk_q[BLK_W-1 -: AW]) >= eff_words) begin
      stat_d = STAT_RANGE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q  <= op_e'(req_i.operation);
      blk_q <= req_i.block_index;
    end
    if (map_re) begin
      stat_q <= stat_d;
      addr_q <= addr_d;
    end
  end

  fbba_first_free u_first_free (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_words_i (eff_words),
    .upd_i       (upd),
    .found_o     (found),
    .word_o      (found_word)
  );

  fbba_map_ram u_map_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (map_re),
    .raddr_i (addr_d),
    .rdata_o (rdata),
    .we_i    (map_we),
    .waddr_i (addr_q),
    .wdata_i (wdata)
  );

  assign ok       = (stat_q == STAT_OK);
  assign low_bit  = lowest32(rdata);
  assign bit_mask = word_t'(1) << ((op_q == OP_ALLOC) ? low_bit : blk_q[BIT_W-1:0]);

  always_comb begin
    case (op_q)
      OP_FREE: wdata = rdata | bit_mask;
      default: wdata = rdata & ~bit_mask;
    endcase
  end

  assign map_we   = out_load && ok && (op_q != OP_CHECK);
  assign upd.en   = map_we;
  assign upd.addr = addr_q;
  assign upd.nz   = |wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_stat_q <= stat_q;
      out_blk_q  <= (ok && op_q == OP_ALLOC) ? {addr_q, low_bit} : '0;
      out_used_q <= ok && (op_q == OP_CHECK) && !rdata[blk_q[BIT_W-1:0]];
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.allocated_block = out_blk_q;
  assign rsp_o.is_allocated    = out_used_q;
  assign rsp_o.status          = out_stat_q;

  a_look_to_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK |=> state_q == S_MOD)
    else $error("lookup not followed by modify");
  a_rsp_from_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_MOD)
    else $error("response raised outside modify step");
  a_write_ok_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_we |-> open_q && (WIN_W'(addr_q) < eff_words))
    else $error("bitmap written for a failed request");

endmodule
